### src/rmq_pkg.sv
// Package with the beat types and widths of the rotation matrix to quaternion converter.
`default_nettype none
package rmq_pkg;

  localparam int unsigned ElemW = 16;
  localparam int unsigned SumW  = 19;
  localparam int unsigned Lanes = 4;
  localparam logic signed [SumW-1:0] OneQ14 = 19'sd16384;

  typedef struct packed {
    logic signed [ElemW-1:0] e00;
    logic signed [ElemW-1:0] e01;
    logic signed [ElemW-1:0] e02;
    logic signed [ElemW-1:0] e10;
    logic signed [ElemW-1:0] e11;
    logic signed [ElemW-1:0] e12;
    logic signed [ElemW-1:0] e20;
    logic signed [ElemW-1:0] e21;
    logic signed [ElemW-1:0] e22;
  } in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] qx;
    logic signed [ElemW-1:0] qy;
    logic signed [ElemW-1:0] qz;
    logic signed [ElemW-1:0] qw;
    logic                    bad_input;
  } out_t;

  typedef struct packed {
    logic                        bad;
    logic [SumW-1:0]             t;
    logic [Lanes-1:0][SumW-1:0]  c;
  } work_t;

endpackage
`default_nettype wire

### src/rmq_front.sv
// Front end: picks the branch from the diagonal and forms t and the raw components.
`default_nettype none
module rmq_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          acc_i,
  input  wire rmq_pkg::in_t  in_i,
  output logic               vld_o,
  output rmq_pkg::work_t     work_o
);

  logic signed [18:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, t;
  logic signed [18:0] c0, c1, c2, c3;
  logic               vld_q;
  rmq_pkg::work_t     work_q, work_d;

  always_comb begin
    a00 = 19'(in_i.e00); a01 = 19'(in_i.e01); a02 = 19'(in_i.e02);
    a10 = 19'(in_i.e10); a11 = 19'(in_i.e11); a12 = 19'(in_i.e12);
    a20 = 19'(in_i.e20); a21 = 19'(in_i.e21); a22 = 19'(in_i.e22);
    if (a22 < 0) begin
      if (a00 > a11) begin
        t = rmq_pkg::OneQ14 + a00 - a11 - a22;
        c0 = t; c1 = a01 + a10; c2 = a20 + a02; c3 = a12 - a21;
      end else begin
        t = rmq_pkg::OneQ14 - a00 + a11 - a22;
        c0 = a01 + a10; c1 = t; c2 = a12 + a21; c3 = a20 - a02;
      end
    end else begin
      if ((a00 + a11) < 0) begin
        t = rmq_pkg::OneQ14 - a00 - a11 + a22;
        c0 = a20 + a02; c1 = a12 + a21; c2 = t; c3 = a01 - a10;
      end else begin
        t = rmq_pkg::OneQ14 + a00 + a11 + a22;
        c0 = a12 - a21; c1 = a20 - a02; c2 = a01 - a10; c3 = t;
      end
    end
    work_d.bad  = (t <= 0);
    work_d.t    = t;
    work_d.c[0] = c0;
    work_d.c[1] = c1;
    work_d.c[2] = c2;
    work_d.c[3] = c3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      work_q <= work_d;
    end
  end

  assign vld_o  = vld_q;
  assign work_o = work_q;

endmodule
`default_nettype wire

### src/rmq_queue.sv
// Two-entry queue between the front end and the scaling pipeline.
`default_nettype none
module rmq_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rmq_pkg::work_t data_i,
  input  wire logic           pop_i,
  output logic                nempty_o,
  output logic                full_o,
  output rmq_pkg::work_t      data_o
);

  rmq_pkg::work_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           do_pop;

  assign do_pop   = pop_i && (cnt_q != 2'd0);
  assign nempty_o = (cnt_q != 2'd0);
  assign full_o   = (cnt_q == 2'd2);
  assign data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### src/rmq_back.sv
// Scaling pipeline: one result bit per stage of 64*c/sqrt(t), rounded and saturated.
`default_nettype none
module rmq_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           vld_i,
  input  wire rmq_pkg::work_t work_i,
  output logic                vld_o,
  output rmq_pkg::out_t       res_o
);

  localparam int unsigned NStg = 17;

  logic [NStg-1:0]                  vld_q, bad_q;
  logic [NStg-1:0][16:0]            t_q;
  logic [NStg-1:0][3:0]             neg_q;
  logic [NStg-1:0][3:0][15:0]       lo_q;
  logic [NStg-1:0][3:0][55:0]       p_q;
  logic [NStg-1:0][3:0][36:0]       dt_q;
  logic [NStg-1:0][3:0][49:0]       rhs_q;
  logic                             vout_q;
  rmq_pkg::out_t                    res_q;
  logic [3:0][15:0]                 q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vout_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[NStg-2:0], vld_i};
      vout_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [18:0] cs;
    logic [17:0]        mag;
    bad_q[0] <= work_i.bad;
    t_q[0]   <= work_i.t[16:0];
    for (int l = 0; l < 4; l++) begin
      cs = $signed(work_i.c[l]);
      mag = cs[18] ? 18'(-cs) : 18'(cs);
      neg_q[0][l] <= cs[18];
      lo_q[0][l]  <= '0;
      rhs_q[0][l] <= {36'(mag) * 36'(mag), 14'b0};
      p_q[0][l]   <= 56'(work_i.t[16:0]);
      dt_q[0][l]  <= -37'(work_i.t[16:0]);
    end
  end

  for (genvar s = 1; s < NStg; s++) begin : g_stg
    localparam int unsigned B = NStg - 1 - s;
    always_ff @(posedge clk_i) begin
      logic signed [55:0] pn, tt;
      logic signed [36:0] dn;
      bad_q[s] <= bad_q[s-1];
      t_q[s]   <= t_q[s-1];
      neg_q[s] <= neg_q[s-1];
      rhs_q[s] <= rhs_q[s-1];
      for (int l = 0; l < 4; l++) begin
        tt = 56'(t_q[s-1]);
        pn = $signed(p_q[s-1][l]) + ($signed(56'($signed(dt_q[s-1][l]))) <<< (B + 2))
             + (tt <<< (2 * B + 2));
        dn = $signed(dt_q[s-1][l]) + 37'(tt <<< (B + 1));
        if (!lo_q[s-1][l][15] && (pn <= $signed({6'b0, rhs_q[s-1][l]}))) begin
          lo_q[s][l] <= lo_q[s-1][l] | 16'(1 << B);
          p_q[s][l]  <= pn;
          dt_q[s][l] <= dn;
        end else begin
          lo_q[s][l] <= lo_q[s-1][l];
          p_q[s][l]  <= p_q[s-1][l];
          dt_q[s][l] <= dt_q[s-1][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (bad_q[NStg-1]) begin
        q[l] = '0;
      end else if (neg_q[NStg-1][l]) begin
        q[l] = -lo_q[NStg-1][l];
      end else begin
        q[l] = lo_q[NStg-1][l][15] ? 16'h7fff : lo_q[NStg-1][l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.qx        <= q[0];
    res_q.qy        <= q[1];
    res_q.qz        <= q[2];
    res_q.qw        <= q[3];
    res_q.bad_input <= bad_q[NStg-1];
  end

  assign vld_o = vout_q;
  assign res_o = res_q;

endmodule
`default_nettype wire

### src/rotation_matrix_to_quaternion_core.sv
// Top level of the rotation matrix to quaternion converter.
// A beat passes the front register, the queue, the scaling stages and the output register.
// Throughput: one beat per cycle; the bit-per-stage scaling pipeline sets the depth.
// Reset clears all valid flags and the queue; data registers are not reset.
// The receiver cannot stall, so busy stays low in operation.
`default_nettype none
module rotation_matrix_to_quaternion_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire rmq_pkg::in_t  in_i,
  output logic               busy,
  output logic               valid_o,
  output rmq_pkg::out_t      res_o
);

  logic           acc, f_vld, q_ne, q_full;
  rmq_pkg::work_t f_work, q_work;

  assign acc  = start && !busy;
  assign busy = q_full;

  rmq_front u_front (
    .clk_i, .rst_ni, .acc_i(acc), .in_i, .vld_o(f_vld), .work_o(f_work)
  );

  rmq_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_vld), .data_i(f_work), .pop_i(1'b1),
    .nempty_o(q_ne), .full_o(q_full), .data_o(q_work)
  );

  rmq_back u_back (
    .clk_i, .rst_ni, .vld_i(q_ne), .work_i(q_work), .vld_o(valid_o), .res_o
  );

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##20 valid_o) else $error("result latency broken");
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.bad_input |-> res_o.qx == 0 && res_o.qy == 0 &&
    res_o.qz == 0 && res_o.qw == 0) else $error("bad beat not zeroed");
  a_nofull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_full) else $error("queue filled up");

endmodule
`default_nettype wire
